FILE: design/fnps_pkg.sv
// Shared types and constants for the filtered nearest point search block.
package fnps_pkg;

  localparam int IDX_W       = 6;
  localparam int COORD_W     = 16;
  localparam int MAG_W       = 16;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int DIST_W      = SQ_W + 1;
  localparam int CNT_W       = 7;
  localparam int FIELD_DEPTH = 1 << IDX_W;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [SQ_W-1:0]           sq_t;
  typedef logic [DIST_W-1:0]         dist_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } point_t;

  typedef struct packed {
    logic   en;
    idx_t   idx;
    point_t pt;
    logic   is_empty;
    logic   keep;
  } wr_req_t;

  typedef struct packed {
    logic vld;
    logic hit;
    logic last;
    idx_t idx;
  } scan_tag_t;

endpackage

FILE: design/fnps_in_if.sv
// Request channel: valid/ready handshake with write or query payload.
interface fnps_in_if import fnps_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   req_type;
  idx_t   entry_index;
  coord_t pos_x;
  coord_t pos_y;
  logic   entry_is_empty;
  logic   entry_keep;
  logic   want_occupied;

  modport source (
    output valid, req_type, entry_index, pos_x, pos_y, entry_is_empty, entry_keep,
           want_occupied,
    input  ready
  );

  modport sink (
    input  valid, req_type, entry_index, pos_x, pos_y, entry_is_empty, entry_keep,
           want_occupied,
    output ready
  );
endinterface

FILE: design/fnps_out_if.sv
// Result channel: valid/ready handshake with search result payload.
interface fnps_out_if import fnps_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  found;
  idx_t  match_index;
  dist_t match_distance;
  cnt_t  empty_count;

  modport source (
    output valid, found, match_index, match_distance, empty_count,
    input  ready
  );

  modport sink (
    input  valid, found, match_index, match_distance, empty_count,
    output ready
  );
endinterface

FILE: design/filtered_nearest_point_search_top.sv
// Filtered nearest point search: table of 2-D points, one-entry-per-cycle scan for the
// nearest empty or occupied entry. The scan covers LIVE_DEPTH entries, the smaller of
// TABLE_DEPTH and 64, since the index field reaches only 64 entries. The query time is
// set by the scan, which reads one entry per cycle from the single-read-port point
// memory into the three-stage shared distance unit. A finished result sits in an output
// register, so the next request is accepted while it waits to be taken. Ties go to the
// lowest index.
module filtered_nearest_point_search_top import fnps_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input logic         clk,
  input logic         rst_n,
  fnps_in_if.sink     in_ch,
  fnps_out_if.source  out_ch
);

  localparam int LIVE_DEPTH = (TABLE_DEPTH < FIELD_DEPTH) ? TABLE_DEPTH : FIELD_DEPTH;

  wr_req_t   wr;
  scan_tag_t iss_tag;
  scan_tag_t rd_tag;
  scan_tag_t d_tag;
  point_t    rd_pt;
  logic      want_empty;
  coord_t    qx;
  coord_t    qy;
  dist_t     d_sum;
  cnt_t      empty_total;

  fnps_seq #(
    .LIVE_DEPTH (LIVE_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .wr          (wr),
    .iss_tag     (iss_tag),
    .want_empty  (want_empty),
    .qx          (qx),
    .qy          (qy),
    .d_tag       (d_tag),
    .d_sum       (d_sum),
    .empty_total (empty_total)
  );

  fnps_store #(
    .LIVE_DEPTH (LIVE_DEPTH)
  ) u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr          (wr),
    .iss_tag     (iss_tag),
    .want_empty  (want_empty),
    .rd_tag      (rd_tag),
    .rd_pt       (rd_pt),
    .empty_total (empty_total)
  );

  fnps_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (rd_tag),
    .pt      (rd_pt),
    .qx      (qx),
    .qy      (qy),
    .out_tag (d_tag),
    .sum     (d_sum)
  );

endmodule

FILE: design/fnps_store.sv
// Point memory, per-entry valid and empty-count flags, and the running empty total.
module fnps_store import fnps_pkg::*; #(
  parameter int LIVE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  wr_req_t   wr,
  input  scan_tag_t iss_tag,
  input  logic      want_empty,
  output scan_tag_t rd_tag,
  output point_t    rd_pt,
  output cnt_t      empty_total
);

  localparam int AW = (LIVE_DEPTH > 1) ? $clog2(LIVE_DEPTH) : 1;

  point_t                mem [LIVE_DEPTH];
  point_t                rd_pt_r;
  logic [LIVE_DEPTH-1:0] valid_r;
  logic [LIVE_DEPTH-1:0] cnt_r;
  cnt_t                  total_r;
  cnt_t                  total_nxt;
  scan_tag_t             tag_r;
  scan_tag_t             tag_nxt;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic                  new_cnt;

  assign waddr   = wr.idx[AW-1:0];
  assign raddr   = iss_tag.idx[AW-1:0];
  assign new_cnt = wr.keep & wr.is_empty;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.pt;
    end
    rd_pt_r <= mem[raddr];
  end

  always_comb begin
    total_nxt = total_r;
    if (wr.en) begin
      total_nxt = total_r - cnt_t'(cnt_r[waddr]) + cnt_t'(new_cnt);
    end
  end

  always_comb begin
    tag_nxt     = iss_tag;
    tag_nxt.hit = iss_tag.vld & valid_r[raddr] & (cnt_r[raddr] == want_empty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
      total_r <= '0;
      tag_r   <= '0;
    end else begin
      if (wr.en) begin
        valid_r[waddr] <= wr.keep;
        cnt_r[waddr]   <= new_cnt;
      end
      total_r <= total_nxt;
      tag_r   <= tag_nxt;
    end
  end

  assign rd_tag      = tag_r;
  assign rd_pt       = rd_pt_r;
  assign empty_total = total_r;

  a_total_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
    total_r == cnt_t'($countones(cnt_r)))
    else $error("empty total out of step with entry flags");

  a_counted_implies_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r & ~valid_r) == '0)
    else $error("empty flag set on an invalid entry");

endmodule

FILE: design/fnps_dist.sv
// Shared squared-distance pipeline: difference magnitude, squares, sum.
module fnps_dist import fnps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  scan_tag_t in_tag,
  input  point_t    pt,
  input  coord_t    qx,
  input  coord_t    qy,
  output scan_tag_t out_tag,
  output dist_t     sum
);

  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  scan_tag_t               t2_r;
  scan_tag_t               t3_r;
  scan_tag_t               t4_r;
  mag_t                    mx_r;
  mag_t                    my_r;
  sq_t                     sx_r;
  sq_t                     sy_r;
  dist_t                   sum_r;

  assign dx = (COORD_W+1)'(pt.x) - (COORD_W+1)'(qx);
  assign dy = (COORD_W+1)'(pt.y) - (COORD_W+1)'(qy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_r <= '0;
      t3_r <= '0;
      t4_r <= '0;
    end else begin
      t2_r <= in_tag;
      t3_r <= t2_r;
      t4_r <= t3_r;
    end
  end

  always_ff @(posedge clk) begin
    mx_r  <= dx[COORD_W] ? mag_t'(-dx) : mag_t'(dx);
    my_r  <= dy[COORD_W] ? mag_t'(-dy) : mag_t'(dy);
    sx_r  <= sq_t'(mx_r) * sq_t'(mx_r);
    sy_r  <= sq_t'(my_r) * sq_t'(my_r);
    sum_r <= dist_t'(sx_r) + dist_t'(sy_r);
  end

  assign out_tag = t4_r;
  assign sum     = sum_r;

endmodule

FILE: design/fnps_seq.sv
// Request sequencer: handshake, scan address issue, best-match tracking, result register.
module fnps_seq import fnps_pkg::*; #(
  parameter int LIVE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  fnps_in_if.sink           in_ch,
  fnps_out_if.source        out_ch,
  output wr_req_t           wr,
  output scan_tag_t         iss_tag,
  output logic              want_empty,
  output coord_t            qx,
  output coord_t            qy,
  input  scan_tag_t         d_tag,
  input  dist_t             d_sum,
  input  cnt_t              empty_total
);

  seq_state_t state_r;
  seq_state_t state_nxt;
  idx_t       addr_r;
  idx_t       addr_nxt;
  logic       issuing_r;
  logic       issuing_nxt;
  coord_t     qx_r;
  coord_t     qy_r;
  logic       want_empty_r;
  logic       found_r;
  idx_t       best_idx_r;
  dist_t      best_dist_r;
  logic       out_valid_r;
  logic       out_found_r;
  idx_t       out_idx_r;
  dist_t      out_dist_r;
  cnt_t       out_cnt_r;
  logic       in_acc;
  logic       is_query;
  logic       out_load;
  logic       better;
  logic       addr_last;

  assign in_acc    = in_ch.valid & in_ch.ready;
  assign is_query  = (in_ch.req_type == REQ_QUERY);
  assign addr_last = (addr_r == idx_t'(LIVE_DEPTH - 1));
  assign better    = d_tag.vld & d_tag.hit & (~found_r | (d_sum < best_dist_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: begin
        if (in_acc) begin
          state_nxt = is_query ? SEQ_SCAN : SEQ_DONE;
        end
      end
      SEQ_SCAN: begin
        if (d_tag.vld && d_tag.last) begin
          state_nxt = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (out_load) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = (state_r == SEQ_IDLE);
    out_load    = (state_r == SEQ_DONE) & (~out_valid_r | out_ch.ready);
    iss_tag     = '0;
    iss_tag.vld  = (state_r == SEQ_SCAN) & issuing_r;
    iss_tag.last = addr_last;
    iss_tag.idx  = addr_r;
    wr.en       = in_acc & ~is_query & (int'(in_ch.entry_index) < LIVE_DEPTH);
    wr.idx      = in_ch.entry_index;
    wr.pt.x     = in_ch.pos_x;
    wr.pt.y     = in_ch.pos_y;
    wr.is_empty = in_ch.entry_is_empty;
    wr.keep     = in_ch.entry_keep;
  end

  // scan address counter
  always_comb begin
    addr_nxt    = addr_r;
    issuing_nxt = issuing_r;
    if (in_acc) begin
      addr_nxt    = '0;
      issuing_nxt = is_query;
    end else if (iss_tag.vld) begin
      if (addr_last) begin
        issuing_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      addr_r      <= '0;
      issuing_r   <= 1'b0;
      found_r     <= 1'b0;
      best_idx_r  <= '0;
      best_dist_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      issuing_r <= issuing_nxt;
      if (in_acc) begin
        found_r     <= 1'b0;
        best_idx_r  <= '0;
        best_dist_r <= '0;
      end else if (better) begin
        found_r     <= 1'b1;
        best_idx_r  <= d_tag.idx;
        best_dist_r <= d_sum;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      qx_r         <= in_ch.pos_x;
      qy_r         <= in_ch.pos_y;
      want_empty_r <= ~in_ch.want_occupied;
    end
    if (out_load) begin
      out_found_r <= found_r;
      out_idx_r   <= best_idx_r;
      out_dist_r  <= best_dist_r;
      out_cnt_r   <= empty_total;
    end
  end

  assign qx                    = qx_r;
  assign qy                    = qy_r;
  assign want_empty            = want_empty_r;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.match_index    = out_idx_r;
  assign out_ch.match_distance = out_dist_r;
  assign out_ch.empty_count    = out_cnt_r;

  a_tag_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    d_tag.vld |-> state_r == SEQ_SCAN)
    else $error("distance result outside a scan");

  a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (d_tag.vld && d_tag.last) |=> state_r == SEQ_DONE)
    else $error("scan did not finish after last entry");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !found_r) |-> (best_dist_r == '0 && best_idx_r == '0))
    else $error("miss result carries nonzero match fields");

endmodule
